// File: rtl/mdnsv_pkg.sv
// ----------------------------------------------------------------------------
// mdnsv_pkg
// Types and constants shared by the mDNS message validator.
// ----------------------------------------------------------------------------
`default_nettype none

package mdnsv_pkg;

  localparam int unsigned DATA_W   = 8;
  localparam int unsigned COUNT_W  = 16;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned CFG_ADDR_W = 8;
  localparam int unsigned CFG_DATA_W = 8;
  localparam int unsigned LABEL_W  = 6;
  localparam int unsigned LIMIT_W  = 8;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK         = 3'd0;
  localparam logic [STATUS_W-1:0] ST_BAD_OPCODE = 3'd1;
  localparam logic [STATUS_W-1:0] ST_BAD_LABEL  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_BAD_TYPE   = 3'd3;
  localparam logic [STATUS_W-1:0] ST_BAD_CLASS  = 3'd4;
  localparam logic [STATUS_W-1:0] ST_TRUNCATED  = 3'd5;

  // register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_MAX_LABEL = 8'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_MAX_QUEST = 8'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_MAX_ANSW  = 8'd2;

  localparam logic [LABEL_W-1:0] RST_MAX_LABEL = 6'd63;
  localparam logic [LIMIT_W-1:0] RST_MAX_QUEST = 8'd8;
  localparam logic [LIMIT_W-1:0] RST_MAX_ANSW  = 8'd8;

  // header byte offsets
  localparam logic [COUNT_W-1:0] OFF_FLAGS_HI = 16'd2;
  localparam logic [COUNT_W-1:0] OFF_QD_HI    = 16'd4;
  localparam logic [COUNT_W-1:0] OFF_QD_LO    = 16'd5;
  localparam logic [COUNT_W-1:0] OFF_AN_HI    = 16'd6;
  localparam logic [COUNT_W-1:0] OFF_AN_LO    = 16'd7;
  localparam logic [COUNT_W-1:0] OFF_HDR_LAST = 16'd11;
  localparam logic [COUNT_W-1:0] OFF_MAX      = 16'hFFFF;

  localparam logic [DATA_W-1:0]  PTR_MASK    = 8'hC0;
  localparam logic [COUNT_W-1:0] CLASS_FLUSH = 16'h8000;
  localparam logic [COUNT_W-1:0] CLASS_IN    = 16'h0001;
  localparam logic [COUNT_W-1:0] TYPE_MAX    = 16'd255;

  // fixed-field byte counts
  localparam logic [3:0] QF_TYPE_END = 4'd2;
  localparam logic [3:0] QF_END      = 4'd4;
  localparam logic [3:0] AF_END      = 4'd10;

  typedef enum logic [3:0] {
    PH_HEADER,
    PH_QNAME,
    PH_QPTR2,
    PH_QLABEL,
    PH_QFIXED,
    PH_ANAME,
    PH_APTR2,
    PH_ALABEL,
    PH_AFIXED,
    PH_ARDATA,
    PH_DONE,
    PH_ERR
  } phase_t;

  typedef struct packed {
    logic [LABEL_W-1:0] max_label;
    logic [LIMIT_W-1:0] max_quest;
    logic [LIMIT_W-1:0] max_answ;
  } cfg_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [COUNT_W-1:0]  question_count;
    logic [COUNT_W-1:0]  answer_count;
    logic [COUNT_W-1:0]  end_offset;
  } result_t;

endpackage

`default_nettype wire

// File: rtl/mdnsv_if.sv
// ----------------------------------------------------------------------------
// mdnsv_if
// Valid/ready channels of the mDNS message validator: byte in, result out,
// register write.
// ----------------------------------------------------------------------------
`default_nettype none

interface mdnsv_in_if;
  import mdnsv_pkg::*;
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] data_byte;
  logic              last_byte;
  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface mdnsv_out_if;
  import mdnsv_pkg::*;
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [COUNT_W-1:0]  question_count;
  logic [COUNT_W-1:0]  answer_count;
  logic [COUNT_W-1:0]  end_offset;
  modport source (output valid, output status, output question_count,
                  output answer_count, output end_offset, input ready);
  modport sink   (input valid, input status, input question_count,
                  input answer_count, input end_offset, output ready);
endinterface

interface mdnsv_cfg_if;
  import mdnsv_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_ADDR_W-1:0] addr;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, output addr, output data, input ready);
  modport sink   (input valid, input addr, input data, output ready);
endinterface

`default_nettype wire

// File: rtl/mdnsv_cfg_regs.sv
// ----------------------------------------------------------------------------
// mdnsv_cfg_regs
// Limit registers: label length, question count, answer count.
// ----------------------------------------------------------------------------
`default_nettype none

module mdnsv_cfg_regs (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              wr_en,
  input  wire [mdnsv_pkg::CFG_ADDR_W-1:0]  wr_addr,
  input  wire [mdnsv_pkg::CFG_DATA_W-1:0]  wr_data,
  output mdnsv_pkg::cfg_t                  cfg
);
  import mdnsv_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (wr_addr)
        REG_MAX_LABEL: cfg_nxt.max_label = wr_data[LABEL_W-1:0];
        REG_MAX_QUEST: cfg_nxt.max_quest = wr_data[LIMIT_W-1:0];
        REG_MAX_ANSW:  cfg_nxt.max_answ  = wr_data[LIMIT_W-1:0];
        default:       cfg_nxt = cfg_r; // unknown index: dropped
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.max_label <= RST_MAX_LABEL;
      cfg_r.max_quest <= RST_MAX_QUEST;
      cfg_r.max_answ  <= RST_MAX_ANSW;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

// File: rtl/mdnsv_parser.sv
// ----------------------------------------------------------------------------
// mdnsv_parser
// Per-byte DNS message walker: header, questions, answers. Updates its state
// on each stepped byte and presents the result for a last byte.
// ----------------------------------------------------------------------------
`default_nettype none

module mdnsv_parser (
  input  wire                           clk,
  input  wire                           rst_n,
  input  wire                           step,
  input  wire [mdnsv_pkg::DATA_W-1:0]   data_byte,
  input  wire                           last_byte,
  input  mdnsv_pkg::cfg_t               cfg,
  output mdnsv_pkg::result_t            res
);
  import mdnsv_pkg::*;

  phase_t               phase_r, phase_nxt;
  logic [COUNT_W-1:0]   offset_r, offset_nxt;
  logic [3:0]           fidx_r, fidx_nxt;
  logic [COUNT_W-1:0]   fshift_r, fshift_nxt;
  logic [COUNT_W-1:0]   qd_r, qd_nxt;
  logic [COUNT_W-1:0]   an_r, an_nxt;
  logic [LIMIT_W-1:0]   rec_r, rec_nxt;
  logic [COUNT_W-1:0]   skip_r, skip_nxt;
  logic [STATUS_W-1:0]  err_r, err_nxt;

  // values after this byte, before the end-of-message clear
  phase_t               ph_c;
  logic [COUNT_W-1:0]   off_c, fshift_c, qd_c, an_c, skip_c;
  logic [3:0]           fidx_c;
  logic [LIMIT_W-1:0]   rec_c;
  logic [STATUS_W-1:0]  err_c;

  logic [COUNT_W-1:0]   fs_shift;
  logic [3:0]           fidx_inc;
  logic [COUNT_W-1:0]   skip_dec;
  logic [LIMIT_W:0]     rec_inc;
  logic                 have_q, have_a, q_more, a_more, ans;
  logic                 active;

  assign fs_shift = {fshift_r[COUNT_W-DATA_W-1:0], data_byte};
  assign fidx_inc = fidx_r + 4'd1;
  assign skip_dec = skip_r - 16'd1;
  assign rec_inc  = {1'b0, rec_r} + 9'd1;
  assign have_q   = (qd_r != '0) && (cfg.max_quest != '0);
  assign have_a   = (an_r != '0) && (cfg.max_answ != '0);
  assign q_more   = ({8'd0, rec_inc} < {1'b0, qd_r}) && (rec_inc < {1'b0, cfg.max_quest});
  assign a_more   = ({8'd0, rec_inc} < {1'b0, an_r}) && (rec_inc < {1'b0, cfg.max_answ});
  assign ans      = (phase_r == PH_ANAME) || (phase_r == PH_ALABEL);
  assign active   = (phase_r != PH_DONE) && (phase_r != PH_ERR);

  always_comb begin
    ph_c     = phase_r;
    fidx_c   = fidx_r;
    fshift_c = fshift_r;
    qd_c     = qd_r;
    an_c     = an_r;
    rec_c    = rec_r;
    skip_c   = skip_r;
    err_c    = err_r;
    off_c    = offset_r;
    if (step) begin
      if (active && offset_r != OFF_MAX) off_c = offset_r + 16'd1;
      unique case (phase_r)
        PH_HEADER: begin
          if (offset_r == OFF_FLAGS_HI && data_byte[6:3] != 4'd0) err_c = ST_BAD_OPCODE;
          if (offset_r == OFF_QD_HI) qd_c = {data_byte, 8'h00};
          if (offset_r == OFF_QD_LO) qd_c = {qd_r[15:8], data_byte};
          if (offset_r == OFF_AN_HI) an_c = {data_byte, 8'h00};
          if (offset_r == OFF_AN_LO) an_c = {an_r[15:8], data_byte};
          if (offset_r == OFF_HDR_LAST) begin
            rec_c = '0;
            if (err_c != ST_OK) ph_c = PH_ERR;
            else if (have_q)    ph_c = PH_QNAME;
            else if (have_a)    ph_c = PH_ANAME;
            else                ph_c = PH_DONE;
          end
        end
        PH_QNAME, PH_ANAME: begin
          if (data_byte == 8'h00) begin
            fidx_c   = '0;
            fshift_c = '0;
            ph_c     = ans ? PH_AFIXED : PH_QFIXED;
          end else if ((data_byte & PTR_MASK) != 8'h00) begin
            ph_c = ans ? PH_APTR2 : PH_QPTR2;
          end else if (data_byte[LABEL_W-1:0] <= cfg.max_label) begin
            // top bits are clear here, so the low bits are the whole length
            skip_c = {8'd0, data_byte};
            ph_c   = ans ? PH_ALABEL : PH_QLABEL;
          end else begin
            err_c = ST_BAD_LABEL;
            ph_c  = PH_ERR;
          end
        end
        PH_QPTR2, PH_APTR2: begin
          fidx_c   = '0;
          fshift_c = '0;
          ph_c     = (phase_r == PH_APTR2) ? PH_AFIXED : PH_QFIXED;
        end
        PH_QLABEL, PH_ALABEL: begin
          skip_c = skip_dec;
          if (skip_dec == '0) ph_c = ans ? PH_ANAME : PH_QNAME;
        end
        PH_QFIXED: begin
          fshift_c = fs_shift;
          fidx_c   = fidx_inc;
          if (fidx_inc == QF_TYPE_END) begin
            if (fs_shift > TYPE_MAX) begin
              err_c = ST_BAD_TYPE;
              ph_c  = PH_ERR;
            end else begin
              fshift_c = '0;
            end
          end else if (fidx_inc == QF_END) begin
            if ((fs_shift & ~CLASS_FLUSH) != CLASS_IN) begin
              err_c = ST_BAD_CLASS;
              ph_c  = PH_ERR;
            end else if (q_more) begin
              rec_c = rec_inc[LIMIT_W-1:0];
              ph_c  = PH_QNAME;
            end else begin
              rec_c = '0;
              ph_c  = have_a ? PH_ANAME : PH_DONE;
            end
          end
        end
        PH_AFIXED: begin
          fshift_c = fs_shift;
          fidx_c   = fidx_inc;
          if (fidx_inc == AF_END) begin
            skip_c = fs_shift;
            if (fs_shift == '0) begin
              rec_c = rec_inc[LIMIT_W-1:0];
              ph_c  = a_more ? PH_ANAME : PH_DONE;
            end else begin
              ph_c = PH_ARDATA;
            end
          end
        end
        PH_ARDATA: begin
          skip_c = skip_dec;
          if (skip_dec == '0) begin
            rec_c = rec_inc[LIMIT_W-1:0];
            ph_c  = a_more ? PH_ANAME : PH_DONE;
          end
        end
        default: ph_c = phase_r;
      endcase
    end
  end

  always_comb begin
    res.question_count = qd_c;
    res.answer_count   = an_c;
    res.end_offset     = off_c;
    if (ph_c == PH_ERR)       res.status = err_c;
    else if (ph_c == PH_DONE) res.status = ST_OK;
    else                      res.status = ST_TRUNCATED;
  end

  // a last byte closes the message and clears the walk
  always_comb begin
    if (step && last_byte) begin
      phase_nxt  = PH_HEADER;
      offset_nxt = '0;
      fidx_nxt   = '0;
      fshift_nxt = '0;
      qd_nxt     = '0;
      an_nxt     = '0;
      rec_nxt    = '0;
      skip_nxt   = '0;
      err_nxt    = ST_OK;
    end else begin
      phase_nxt  = ph_c;
      offset_nxt = off_c;
      fidx_nxt   = fidx_c;
      fshift_nxt = fshift_c;
      qd_nxt     = qd_c;
      an_nxt     = an_c;
      rec_nxt    = rec_c;
      skip_nxt   = skip_c;
      err_nxt    = err_c;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HEADER;
    end else begin
      phase_r <= phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_r <= '0;
      fidx_r   <= '0;
      fshift_r <= '0;
      qd_r     <= '0;
      an_r     <= '0;
      rec_r    <= '0;
      skip_r   <= '0;
      err_r    <= ST_OK;
    end else begin
      offset_r <= offset_nxt;
      fidx_r   <= fidx_nxt;
      fshift_r <= fshift_nxt;
      qd_r     <= qd_nxt;
      an_r     <= an_nxt;
      rec_r    <= rec_nxt;
      skip_r   <= skip_nxt;
      err_r    <= err_nxt;
    end
  end

endmodule

`default_nettype wire

// File: rtl/mdns_message_validator.sv
// ----------------------------------------------------------------------------
// mdns_message_validator
// Byte-stream mDNS message checker with one result per message.
// ----------------------------------------------------------------------------
// Takes one message byte per cycle while input is not stalled, with no gaps
// needed between messages. Each accepted byte sits in an input register, then
// the parser updates its state from it; the result of a byte marked last is
// written to the output register at that same edge, so a result is valid once
// its last byte has passed the input and output registers. The output register
// lets input continue while a result waits; input stalls only when a second
// last byte reaches the parser before the previous result is taken. Limit
// registers are written through the cfg channel (always ready); the user must
// write them only while no message is in flight; not enforced by the block.
`default_nettype none

module mdns_message_validator (
  input  wire          clk,
  input  wire          rst_n,
  mdnsv_in_if.sink     in_ch,
  mdnsv_out_if.source  out_ch,
  mdnsv_cfg_if.sink    cfg_ch
);
  import mdnsv_pkg::*;

  logic              s1_valid_r;
  logic [DATA_W-1:0] s1_byte_r;
  logic              s1_last_r;
  logic              s1_fire;
  logic              out_valid_r;
  logic              out_valid_nxt;
  result_t           out_r;
  result_t           res;
  cfg_t              cfg;

  assign cfg_ch.ready = 1'b1;

  mdnsv_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (cfg_ch.valid),
    .wr_addr (cfg_ch.addr),
    .wr_data (cfg_ch.data),
    .cfg     (cfg)
  );

  // only a last byte needs room in the output register
  assign s1_fire     = s1_valid_r && (!s1_last_r || !out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || s1_fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      s1_byte_r <= in_ch.data_byte;
      s1_last_r <= in_ch.last_byte;
    end
  end

  mdnsv_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (s1_fire),
    .data_byte (s1_byte_r),
    .last_byte (s1_last_r),
    .cfg       (cfg),
    .res       (res)
  );

  always_comb begin
    out_valid_nxt = out_valid_r && !out_ch.ready;
    if (s1_fire && s1_last_r) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && s1_last_r) out_r <= res;
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.status         = out_r.status;
  assign out_ch.question_count = out_r.question_count;
  assign out_ch.answer_count   = out_r.answer_count;
  assign out_ch.end_offset     = out_r.end_offset;

endmodule

`default_nettype wire
